/* hdl/cphe_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cphe_pkg
// Types and constants shared by the capture packet header extractor.
// ---------------------------------------------------------------------------
package cphe_pkg;

   localparam int unsigned GLOBAL_HDR_BYTES = 24;
   localparam int unsigned HDR_BYTES        = 42;

   localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;

   localparam logic [7:0] IP_PROTO_ICMP = 8'h01;
   localparam logic [7:0] IP_PROTO_TCP  = 8'h06;
   localparam logic [7:0] IP_PROTO_UDP  = 8'h11;

   localparam logic [2:0] KIND_OTHER    = 3'd0;
   localparam logic [2:0] KIND_ARP      = 3'd1;
   localparam logic [2:0] KIND_TCP      = 3'd2;
   localparam logic [2:0] KIND_UDP      = 3'd3;
   localparam logic [2:0] KIND_ICMP     = 3'd4;
   localparam logic [2:0] KIND_IP_OTHER = 3'd5;

   typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_type;

   typedef struct packed {
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [15:0] ether_kind;
      logic [2:0]  packet_kind;
      logic [31:0] sender_ip;
      logic [31:0] target_ip;
      logic [15:0] first_port;
      logic [15:0] second_port;
      logic [7:0]  time_to_live;
      logic [7:0]  upper_protocol;
      logic [15:0] arp_operation;
   } pkt_fields_type;

   typedef struct packed {
      logic [31:0]    delta_sec;
      logic [31:0]    delta_usec;
      pkt_fields_type fields;
   } rec_entry_type;

endpackage

/* hdl/cphe_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cphe_front
// Byte-stream parser: skips the global header, assembles record headers,
// captures the leading packet bytes and classifies each finished record.
// ---------------------------------------------------------------------------
module cphe_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_take,
   input  logic [7:0]              data_byte,
   output logic                    rec_push,
   output cphe_pkg::rec_entry_type rec_entry
);

   logic [4:0]             skip_ff, skip_in;
   logic                   body_ff, body_in;
   logic [31:0]            pos_ff, pos_in;
   logic [31:0]            sec_ff, sec_in;
   logic [31:0]            usec_ff, usec_in;
   logic [31:0]            caplen_ff, caplen_in;
   logic [31:0]            first_sec_ff, first_sec_in;
   logic [31:0]            first_usec_ff, first_usec_in;
   logic                   first_seen_ff, first_seen_in;
   cphe_pkg::hdr_bytes_type hdr_ff, hdr_in;

   cphe_pkg::hdr_bytes_type hdr_wr;
   cphe_pkg::hdr_bytes_type push_hdr;
   logic [3:0]             hpos;
   logic [31:0]            ins_word;
   logic [31:0]            pos_inc;
   logic                   in_skip;

   assign hpos     = pos_ff[3:0];
   assign ins_word = 32'(data_byte) << {hpos[1:0], 3'b000};
   assign pos_inc  = pos_ff + 32'd1;
   assign in_skip  = (skip_ff < 5'(cphe_pkg::GLOBAL_HDR_BYTES));

   always_comb begin
      for (int i = 0; i < cphe_pkg::HDR_BYTES; i++) begin
         hdr_wr[i] = (pos_ff == 32'(i)) ? data_byte : hdr_ff[i];
      end
   end

   always_comb begin
      skip_in       = skip_ff;
      body_in       = body_ff;
      pos_in        = pos_ff;
      sec_in        = sec_ff;
      usec_in       = usec_ff;
      caplen_in     = caplen_ff;
      first_sec_in  = first_sec_ff;
      first_usec_in = first_usec_ff;
      first_seen_in = first_seen_ff;
      hdr_in        = hdr_ff;
      rec_push      = 1'b0;
      push_hdr      = '0;
      if (byte_take) begin
         if (in_skip) begin
            skip_in = skip_ff + 5'd1;
         end else if (!body_ff) begin
            // Little-endian words; the first byte of a word clears the rest.
            case (hpos[3:2])
               2'd0: sec_in = (hpos[1:0] == 2'd0) ? ins_word : (sec_ff | ins_word);
               2'd1: usec_in = (hpos[1:0] == 2'd0) ? ins_word : (usec_ff | ins_word);
               2'd2: caplen_in = (hpos[1:0] == 2'd0) ? ins_word : (caplen_ff | ins_word);
               default: ;
            endcase
            if (hpos == 4'd7 && !first_seen_ff) begin
               first_seen_in = 1'b1;
               first_sec_in  = sec_ff;
               first_usec_in = usec_ff | ins_word;
            end
            if (hpos == 4'd15) begin
               hdr_in = '0;
               pos_in = '0;
               if (caplen_ff == 32'd0) begin
                  rec_push = 1'b1;
               end else begin
                  body_in = 1'b1;
               end
            end else begin
               pos_in = 32'(hpos) + 32'd1;
            end
         end else begin
            hdr_in = hdr_wr;
            if (pos_inc >= caplen_ff) begin
               rec_push = 1'b1;
               push_hdr = hdr_wr;
               body_in  = 1'b0;
               pos_in   = '0;
            end else begin
               pos_in = pos_inc;
            end
         end
      end
   end

   // Classification of the finished record.
   always_comb begin
      rec_entry                    = '0;
      rec_entry.delta_sec          = sec_ff - first_sec_ff;
      rec_entry.delta_usec         = usec_ff - first_usec_ff;
      rec_entry.fields.dest_mac    = {push_hdr[0], push_hdr[1], push_hdr[2],
                                      push_hdr[3], push_hdr[4], push_hdr[5]};
      rec_entry.fields.source_mac  = {push_hdr[6], push_hdr[7], push_hdr[8],
                                      push_hdr[9], push_hdr[10], push_hdr[11]};
      rec_entry.fields.ether_kind  = {push_hdr[12], push_hdr[13]};
      rec_entry.fields.packet_kind = cphe_pkg::KIND_OTHER;
      if (rec_entry.fields.ether_kind == cphe_pkg::ETH_TYPE_ARP) begin
         rec_entry.fields.packet_kind   = cphe_pkg::KIND_ARP;
         rec_entry.fields.arp_operation = {push_hdr[20], push_hdr[21]};
         rec_entry.fields.sender_ip     = {push_hdr[28], push_hdr[29],
                                           push_hdr[30], push_hdr[31]};
         rec_entry.fields.target_ip     = {push_hdr[38], push_hdr[39],
                                           push_hdr[40], push_hdr[41]};
      end else if (rec_entry.fields.ether_kind == cphe_pkg::ETH_TYPE_IPV4) begin
         rec_entry.fields.time_to_live   = push_hdr[22];
         rec_entry.fields.upper_protocol = push_hdr[23];
         rec_entry.fields.sender_ip      = {push_hdr[26], push_hdr[27],
                                            push_hdr[28], push_hdr[29]};
         rec_entry.fields.target_ip      = {push_hdr[30], push_hdr[31],
                                            push_hdr[32], push_hdr[33]};
         case (push_hdr[23]) inside
            cphe_pkg::IP_PROTO_TCP, cphe_pkg::IP_PROTO_UDP: begin
               rec_entry.fields.packet_kind =
                  (push_hdr[23] == cphe_pkg::IP_PROTO_TCP) ? cphe_pkg::KIND_TCP
                                                           : cphe_pkg::KIND_UDP;
               rec_entry.fields.first_port  = {push_hdr[34], push_hdr[35]};
               rec_entry.fields.second_port = {push_hdr[36], push_hdr[37]};
            end
            cphe_pkg::IP_PROTO_ICMP: begin
               rec_entry.fields.packet_kind = cphe_pkg::KIND_ICMP;
               rec_entry.fields.first_port  = {push_hdr[34], push_hdr[35]};
            end
            default: rec_entry.fields.packet_kind = cphe_pkg::KIND_IP_OTHER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff       <= '0;
         body_ff       <= 1'b0;
         pos_ff        <= '0;
         first_seen_ff <= 1'b0;
      end else begin
         skip_ff       <= skip_in;
         body_ff       <= body_in;
         pos_ff        <= pos_in;
         first_seen_ff <= first_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      sec_ff        <= sec_in;
      usec_ff       <= usec_in;
      caplen_ff     <= caplen_in;
      first_sec_ff  <= first_sec_in;
      first_usec_ff <= first_usec_in;
      hdr_ff        <= hdr_in;
   end

endmodule

/* hdl/cphe_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cphe_queue
// Two-entry queue of classified records between the parser and the
// result pipeline.
// ---------------------------------------------------------------------------
module cphe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cphe_pkg::rec_entry_type push_entry,
   input  logic                    pop,
   output logic                    head_valid,
   output cphe_pkg::rec_entry_type head_entry,
   output logic                    full
);

   cphe_pkg::rec_entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/cphe_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cphe_back
// Result pipeline: scales the seconds difference, adds the microseconds
// difference and holds the result until it is taken.
// ---------------------------------------------------------------------------
module cphe_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  cphe_pkg::rec_entry_type  head_entry,
   output logic                     pop,
   input  logic                     out_stall,
   output logic                     out_valid,
   output logic [31:0]              out_elapsed,
   output cphe_pkg::pkt_fields_type out_fields
);

   logic                     s1_valid_ff, s1_valid_in;
   logic [31:0]              s1_prod_ff;
   logic [31:0]              s1_usec_ff;
   cphe_pkg::pkt_fields_type s1_fields_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [31:0]              elapsed_ff;
   cphe_pkg::pkt_fields_type fields_ff;

   logic out_load;
   logic s1_ready;

   assign out_load = s1_valid_ff && (!out_valid_ff || !out_stall);
   assign s1_ready = !s1_valid_ff || out_load;
   assign pop      = head_valid && s1_ready;

   always_comb begin
      s1_valid_in  = s1_ready ? head_valid : s1_valid_ff;
      out_valid_in = out_load ? 1'b1 : (out_valid_ff && out_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_prod_ff   <= 32'(head_entry.delta_sec * cphe_pkg::USEC_PER_SEC);
         s1_usec_ff   <= head_entry.delta_usec;
         s1_fields_ff <= head_entry.fields;
      end
      if (out_load) begin
         elapsed_ff <= s1_prod_ff + s1_usec_ff;
         fields_ff  <= s1_fields_ff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_elapsed = elapsed_ff;
   assign out_fields  = fields_ff;

endmodule

/* hdl/capture_packet_header_extractor.sv */
`timescale 1ns / 1ps
// A record's result passes the record queue, the product stage and the output register before it is valid.
// Throughput: one byte per cycle; a record yields at most one item per 16 bytes.
// The input stalls only while the two-entry record queue is full, which needs
// the result side to hold off for several records.
// Reset is synchronous and clears the parser counters, the queue and the pipeline.
// ---------------------------------------------------------------------------
// capture_packet_header_extractor
// Parses a capture byte stream into one header summary per packet record.
// ---------------------------------------------------------------------------
module capture_packet_header_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_elapsed_us,
   output logic [47:0] rsp_dest_mac,
   output logic [47:0] rsp_source_mac,
   output logic [15:0] rsp_ether_kind,
   output logic [2:0]  rsp_packet_kind,
   output logic [31:0] rsp_sender_ip,
   output logic [31:0] rsp_target_ip,
   output logic [15:0] rsp_first_port,
   output logic [15:0] rsp_second_port,
   output logic [7:0]  rsp_time_to_live,
   output logic [7:0]  rsp_upper_protocol,
   output logic [15:0] rsp_arp_operation
);

   logic                     byte_take;
   logic                     rec_push;
   cphe_pkg::rec_entry_type  rec_entry;
   logic                     q_pop;
   logic                     q_valid;
   logic                     q_full;
   cphe_pkg::rec_entry_type  q_entry;
   cphe_pkg::pkt_fields_type out_fields;

   assign req_stall = q_full;
   assign byte_take = req_valid && !req_stall;

   cphe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .data_byte (req_data_byte),
      .rec_push  (rec_push),
      .rec_entry (rec_entry)
   );

   cphe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rec_push),
      .push_entry (rec_entry),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_entry),
      .full       (q_full)
   );

   cphe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_valid),
      .head_entry  (q_entry),
      .pop         (q_pop),
      .out_stall   (rsp_stall),
      .out_valid   (rsp_valid),
      .out_elapsed (rsp_elapsed_us),
      .out_fields  (out_fields)
   );

   assign rsp_dest_mac       = out_fields.dest_mac;
   assign rsp_source_mac     = out_fields.source_mac;
   assign rsp_ether_kind     = out_fields.ether_kind;
   assign rsp_packet_kind    = out_fields.packet_kind;
   assign rsp_sender_ip      = out_fields.sender_ip;
   assign rsp_target_ip      = out_fields.target_ip;
   assign rsp_first_port     = out_fields.first_port;
   assign rsp_second_port    = out_fields.second_port;
   assign rsp_time_to_live   = out_fields.time_to_live;
   assign rsp_upper_protocol = out_fields.upper_protocol;
   assign rsp_arp_operation  = out_fields.arp_operation;

   // The queue is never written while full.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      rec_push |-> !q_full)
      else $error("record queue overflow");

   // A pop always comes from a non-empty queue.
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("record queue underflow");

   a_kind_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_packet_kind <= cphe_pkg::KIND_IP_OTHER))
      else $error("packet kind out of range");

   // Items that are neither ARP nor IPv4 carry only MACs and the ethertype.
   a_other_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_packet_kind == cphe_pkg::KIND_OTHER) |->
         (rsp_sender_ip == 32'd0 && rsp_time_to_live == 8'd0 &&
          rsp_arp_operation == 16'd0 && rsp_first_port == 16'd0))
      else $error("non-IP item carries protocol fields");

endmodule

/* sim/tb_capture_packet_header_extractor.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_capture_packet_header_extractor
// Feeds a synthetic capture file byte by byte and checks every header summary
// against a predictor that parses the same byte stream.
// ---------------------------------------------------------------------------
module tb_capture_packet_header_extractor;

   import cphe_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int RANDOM_BYTES = 650;
   localparam int MIN_RECORDS  = 10;
   localparam int LONG_HOLD    = 900;

   typedef enum int {
      FRAME_RANDOM,
      FRAME_UNKNOWN,
      FRAME_ARP,
      FRAME_TCP,
      FRAME_UDP,
      FRAME_ICMP,
      FRAME_IP_OTHER,
      FRAME_IP_ANY
   } frame_style_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES
   } fill_type;

   typedef struct packed {
      logic [31:0]    elapsed_us;
      pkt_fields_type fields;
   } summary_type;

   // Parses the capture stream on its own and holds the summaries still owed.
   class summary_predictor;
      int unsigned skip_count;
      bit          in_body;
      int unsigned position;
      logic [31:0] stamp_sec;
      logic [31:0] stamp_usec;
      logic [31:0] cap_len;
      logic [31:0] first_sec;
      logic [31:0] first_usec;
      bit          first_seen;
      logic [7:0]  frame_store [HDR_BYTES];
      summary_type expected_summaries [$];
      int unsigned bad_summaries;

      function new();
         skip_count    = 0;
         in_body       = 1'b0;
         position      = 0;
         stamp_sec     = '0;
         stamp_usec    = '0;
         cap_len       = '0;
         first_sec     = '0;
         first_usec    = '0;
         first_seen    = 1'b0;
         bad_summaries = 0;
         foreach (frame_store[i]) frame_store[i] = '0;
      endfunction

      function logic [47:0] grab(int off, int n);
         logic [47:0] v;
         v = '0;
         for (int k = 0; k < n; k++) v = {v[39:0], frame_store[off + k]};
         return v;
      endfunction

      function summary_type summarize();
         summary_type s;
         logic [15:0] etype;
         logic [31:0] dsec;
         logic [31:0] dusec;
         s = '0;
         dsec  = stamp_sec - first_sec;
         dusec = stamp_usec - first_usec;
         s.elapsed_us        = dsec * USEC_PER_SEC + dusec;
         s.fields.dest_mac   = grab(0, 6);
         s.fields.source_mac = grab(6, 6);
         etype = 16'(grab(12, 2));
         s.fields.ether_kind = etype;
         if (etype == ETH_TYPE_ARP) begin
            s.fields.packet_kind   = KIND_ARP;
            s.fields.arp_operation = 16'(grab(20, 2));
            s.fields.sender_ip     = 32'(grab(28, 4));
            s.fields.target_ip     = 32'(grab(38, 4));
         end else if (etype == ETH_TYPE_IPV4) begin
            s.fields.time_to_live   = frame_store[22];
            s.fields.upper_protocol = frame_store[23];
            s.fields.sender_ip      = 32'(grab(26, 4));
            s.fields.target_ip      = 32'(grab(30, 4));
            if (frame_store[23] == IP_PROTO_TCP || frame_store[23] == IP_PROTO_UDP) begin
               s.fields.packet_kind = (frame_store[23] == IP_PROTO_TCP) ? KIND_TCP : KIND_UDP;
               s.fields.first_port  = 16'(grab(34, 2));
               s.fields.second_port = 16'(grab(36, 2));
            end else if (frame_store[23] == IP_PROTO_ICMP) begin
               s.fields.packet_kind = KIND_ICMP;
               s.fields.first_port  = 16'(grab(34, 2));
            end else begin
               s.fields.packet_kind = KIND_IP_OTHER;
            end
         end
         return s;
      endfunction

      function void note_byte(logic [7:0] b);
         logic [3:0]  pos;
         logic [31:0] lane_val;
         if (skip_count < GLOBAL_HDR_BYTES) begin
            skip_count++;
            return;
         end
         if (!in_body) begin
            pos      = position[3:0];
            lane_val = {24'd0, b} << (8 * pos[1:0]);
            // The first byte of each little-endian word replaces the old value.
            case (pos[3:2])
               2'd0: stamp_sec  = (pos[1:0] == 2'd0) ? lane_val : (stamp_sec | lane_val);
               2'd1: begin
                  stamp_usec = (pos[1:0] == 2'd0) ? lane_val : (stamp_usec | lane_val);
                  if (pos == 4'd7 && !first_seen) begin
                     first_seen = 1'b1;
                     first_sec  = stamp_sec;
                     first_usec = stamp_usec;
                  end
               end
               2'd2: cap_len = (pos[1:0] == 2'd0) ? lane_val : (cap_len | lane_val);
               default: ;
            endcase
            if (pos == 4'd15) begin
               foreach (frame_store[i]) frame_store[i] = '0;
               position = 0;
               if (cap_len == 0) expected_summaries.push_back(summarize());
               else in_body = 1'b1;
            end else begin
               position = pos + 1;
            end
            return;
         end
         if (position < HDR_BYTES) frame_store[position] = b;
         position++;
         if (position >= cap_len) begin
            expected_summaries.push_back(summarize());
            in_body  = 1'b0;
            position = 0;
         end
      endfunction

      function string describe(summary_type s);
         return $sformatf({"us=%h dst=%h src=%h et=%h kind=%0d sip=%h tip=%h ",
                           "p1=%h p2=%h ttl=%h proto=%h op=%h"},
                          s.elapsed_us, s.fields.dest_mac, s.fields.source_mac,
                          s.fields.ether_kind, s.fields.packet_kind, s.fields.sender_ip,
                          s.fields.target_ip, s.fields.first_port, s.fields.second_port,
                          s.fields.time_to_live, s.fields.upper_protocol,
                          s.fields.arp_operation);
      endfunction

      function void check_summary(summary_type got);
         summary_type want;
         string       diffs;
         diffs = "";
         if (expected_summaries.size() == 0) begin
            bad_summaries++;
            if (bad_summaries <= 10)
               $display("ERROR %0t: unexpected summary: %s", $realtime, describe(got));
            return;
         end
         want = expected_summaries.pop_front();
         if (got.elapsed_us !== want.elapsed_us) diffs = {diffs, " elapsed_us"};
         if (got.fields.dest_mac !== want.fields.dest_mac) diffs = {diffs, " dest_mac"};
         if (got.fields.source_mac !== want.fields.source_mac) diffs = {diffs, " source_mac"};
         if (got.fields.ether_kind !== want.fields.ether_kind) diffs = {diffs, " ether_kind"};
         if (got.fields.packet_kind !== want.fields.packet_kind) diffs = {diffs, " packet_kind"};
         if (got.fields.sender_ip !== want.fields.sender_ip) diffs = {diffs, " sender_ip"};
         if (got.fields.target_ip !== want.fields.target_ip) diffs = {diffs, " target_ip"};
         if (got.fields.first_port !== want.fields.first_port) diffs = {diffs, " first_port"};
         if (got.fields.second_port !== want.fields.second_port)
            diffs = {diffs, " second_port"};
         if (got.fields.time_to_live !== want.fields.time_to_live)
            diffs = {diffs, " time_to_live"};
         if (got.fields.upper_protocol !== want.fields.upper_protocol)
            diffs = {diffs, " upper_protocol"};
         if (got.fields.arp_operation !== want.fields.arp_operation)
            diffs = {diffs, " arp_operation"};
         if (diffs != "") begin
            bad_summaries++;
            if (bad_summaries <= 10) begin
               $display("ERROR %0t: summary mismatch in%s", $realtime, diffs);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_elapsed_us;
   logic [47:0] rsp_dest_mac;
   logic [47:0] rsp_source_mac;
   logic [15:0] rsp_ether_kind;
   logic [2:0]  rsp_packet_kind;
   logic [31:0] rsp_sender_ip;
   logic [31:0] rsp_target_ip;
   logic [15:0] rsp_first_port;
   logic [15:0] rsp_second_port;
   logic [7:0]  rsp_time_to_live;
   logic [7:0]  rsp_upper_protocol;
   logic [15:0] rsp_arp_operation;

   summary_predictor board = new();

   int          hold_request = 0;
   bit          push_mode = 1'b0;
   int          send_calm = 0;
   int unsigned bytes_sent = 0;
   int          idle_cycles = 0;
   logic [31:0] ts_sec = '0;
   logic [31:0] ts_usec = '0;

   capture_packet_header_extractor i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_elapsed_us     (rsp_elapsed_us),
      .rsp_dest_mac       (rsp_dest_mac),
      .rsp_source_mac     (rsp_source_mac),
      .rsp_ether_kind     (rsp_ether_kind),
      .rsp_packet_kind    (rsp_packet_kind),
      .rsp_sender_ip      (rsp_sender_ip),
      .rsp_target_ip      (rsp_target_ip),
      .rsp_first_port     (rsp_first_port),
      .rsp_second_port    (rsp_second_port),
      .rsp_time_to_live   (rsp_time_to_live),
      .rsp_upper_protocol (rsp_upper_protocol),
      .rsp_arp_operation  (rsp_arp_operation)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Idle cycles before the next item; now and then a stretch with no idling.
   function automatic int draw_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = push_mode ? 0 : draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [31:0] w);
      for (int k = 0; k < 4; k++) send_byte(w[8*k +: 8]);
   endtask

   task automatic send_record(input logic [31:0] sec, input logic [31:0] usec,
                              input logic [31:0] len, input frame_style_type style,
                              input fill_type fill);
      logic [15:0] etype;
      logic [7:0]  proto;
      logic [7:0]  b;
      bit          typed;
      typed = (style != FRAME_RANDOM);
      proto = 8'($urandom_range(0, 255));
      case (style)
         FRAME_ARP:      etype = ETH_TYPE_ARP;
         FRAME_UNKNOWN: begin
            // Near misses of the IPv4 ethertype are as likely as any word.
            etype = ($urandom_range(0, 1) == 0) ? 16'(ETH_TYPE_IPV4 | $urandom_range(1, 15))
                                                : 16'($urandom_range(0, 65535));
         end
         default:        etype = ETH_TYPE_IPV4;
      endcase
      case (style)
         FRAME_TCP:  proto = IP_PROTO_TCP;
         FRAME_UDP:  proto = IP_PROTO_UDP;
         FRAME_ICMP: proto = IP_PROTO_ICMP;
         FRAME_IP_OTHER: begin
            if (proto == IP_PROTO_TCP || proto == IP_PROTO_UDP || proto == IP_PROTO_ICMP)
               proto = proto + 8'd2;
         end
         default: ;
      endcase
      send_word(sec);
      send_word(usec);
      send_word(len);
      send_word($urandom());
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hff;
            default:   b = 8'($urandom_range(0, 255));
         endcase
         if (typed && i == 12) b = etype[15:8];
         if (typed && i == 13) b = etype[7:0];
         if (typed && i == 23 && style != FRAME_ARP && style != FRAME_UNKNOWN) b = proto;
         send_byte(b);
      end
   endtask

   task automatic random_record();
      int r;
      logic [31:0] len;
      fill_type fill;
      r = $urandom_range(0, 99);
      if (r < 12) len = 0;
      else if (r < 45) len = $urandom_range(1, 41);
      else if (r < 65) len = HDR_BYTES;
      else if (r < 95) len = $urandom_range(43, 64);
      else len = $urandom_range(65, 160);
      if ($urandom_range(0, 9) == 0) begin
         ts_sec  = $urandom();
         ts_usec = $urandom();
      end else begin
         ts_usec = ts_usec + $urandom_range(0, 400000);
         if (ts_usec >= USEC_PER_SEC) begin
            ts_usec = ts_usec - USEC_PER_SEC;
            ts_sec  = ts_sec + 1;
         end
      end
      r = $urandom_range(0, 19);
      fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM;
      send_record(ts_sec, ts_usec, len, frame_style_type'($urandom_range(0, 7)), fill);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int          stall_left;
      int          calm;
      summary_type got;
      stall_left = 0;
      calm       = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.elapsed_us            = rsp_elapsed_us;
            got.fields.dest_mac       = rsp_dest_mac;
            got.fields.source_mac     = rsp_source_mac;
            got.fields.ether_kind     = rsp_ether_kind;
            got.fields.packet_kind    = rsp_packet_kind;
            got.fields.sender_ip      = rsp_sender_ip;
            got.fields.target_ip      = rsp_target_ip;
            got.fields.first_port     = rsp_first_port;
            got.fields.second_port    = rsp_second_port;
            got.fields.time_to_live   = rsp_time_to_live;
            got.fields.upper_protocol = rsp_upper_protocol;
            got.fields.arp_operation  = rsp_arp_operation;
            board.check_summary(got);
            stall_left = draw_wait(calm);
         end
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("capture_packet_header_extractor test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned random_start;
      int          records;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Global header, with both byte extremes.
      for (int i = 0; i < GLOBAL_HDR_BYTES; i++)
         send_byte((i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hff : 8'($urandom_range(0, 255)));

      // Directed records. The first one is empty and sets the time origin.
      send_record(32'h12345678, 32'd0, 32'd0, FRAME_RANDOM, FILL_RANDOM);
      send_record(32'h12345678, 32'd999999, HDR_BYTES, FRAME_ARP, FILL_RANDOM);
      send_record(32'h12345679, 32'd17, 32'd60, FRAME_TCP, FILL_RANDOM);
      send_record(32'h12345679, 32'd18, HDR_BYTES, FRAME_UDP, FILL_RANDOM);
      send_record(32'h1234567a, 32'd500, 32'd36, FRAME_ICMP, FILL_RANDOM);
      send_record(32'h1234567a, 32'd501, 32'd34, FRAME_IP_OTHER, FILL_RANDOM);
      send_record(32'h1234567b, 32'd0, 32'd14, FRAME_UNKNOWN, FILL_RANDOM);
      send_record(32'h1234567b, 32'd1, 32'd30, FRAME_ARP, FILL_RANDOM);
      send_record(32'h1234567c, 32'd2, 32'd1, FRAME_RANDOM, FILL_ONES);
      send_record(32'hffffffff, 32'hffffffff, HDR_BYTES, FRAME_RANDOM, FILL_ONES);
      send_record(32'd0, 32'd0, HDR_BYTES, FRAME_RANDOM, FILL_ZERO);
      send_record(32'd1, 32'd999999, 32'd300, FRAME_TCP, FILL_RANDOM);
      send_record(32'd2, 32'd0, HDR_BYTES, FRAME_TCP, FILL_ONES);
      send_record(32'd3, 32'd0, HDR_BYTES, FRAME_IP_ANY, FILL_ZERO);

      random_start = bytes_sent;
      records      = 0;
      ts_sec       = 32'd5;
      while (bytes_sent - random_start < RANDOM_BYTES || records < MIN_RECORDS) begin
         if (records == 3) begin
            // Hold the result side off while empty records arrive back to back,
            // so that the record queue fills and the input stalls.
            hold_request = LONG_HOLD;
            push_mode    = 1'b1;
            for (int k = 0; k < 8; k++) send_record(ts_sec, ts_usec + k, 32'd0,
                                                    FRAME_RANDOM, FILL_RANDOM);
            push_mode = 1'b0;
         end
         if (records == 8) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.expected_summaries.size() != 0) @(posedge clock);
         end
         random_record();
         records++;
      end

      req_valid <= 1'b0;
      while (board.expected_summaries.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.bad_summaries == 0 && board.expected_summaries.size() == 0) begin
         $display("capture_packet_header_extractor test passed");
      end else begin
         $display("capture_packet_header_extractor test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/cphe_pkg.sv
hdl/cphe_front.sv
hdl/cphe_queue.sv
hdl/cphe_back.sv
hdl/capture_packet_header_extractor.sv
sim/tb_capture_packet_header_extractor.sv
